[rtl/core/biq_pkg.sv]
// shared types, constants and helpers of the biquad cascade core
`timescale 1ns / 1ps

package biq_pkg;

  localparam int MAX_STAGES = 8;
  localparam int STAGE_W    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

  localparam int NUM_COEF   = 5;
  localparam int NUM_HIST   = 4;
  localparam int COEF_DEPTH = NUM_COEF * MAX_STAGES;
  localparam int HIST_DEPTH = NUM_HIST * MAX_STAGES;
  localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  localparam int SAMPLE_W  = 16;
  localparam int ACC_W     = 35;
  localparam int FRAC_BITS = 15;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

  localparam logic [1:0] CMD_FILTER = 2'd0;
  localparam logic [1:0] CMD_COEF   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [2:0] SLOT_LAST = 3'd4;

  localparam logic CFG_NUM_STAGES = 1'b0;
  localparam logic CFG_POST_SHIFT = 1'b1;

  localparam int         STEP_W         = 3;
  localparam logic [2:0] STEP_ISSUE_END = 3'd4;
  localparam logic [2:0] STEP_X1        = 3'd2;
  localparam logic [2:0] STEP_Y1        = 3'd4;
  localparam logic [2:0] STEP_ACC_FIRST = 3'd2;
  localparam logic [2:0] STEP_ACC_LAST  = 3'd6;
  localparam logic [2:0] STEP_OUT       = 3'd7;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[SAMPLE_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/biquad_cascade_df1_q15_core.sv]
// top level of the direct-form-I biquad cascade on q15 words
`timescale 1ns / 1ps

// Cascade of up to eight direct-form-I biquad sections on Q15 words, run on one
// shared 16x16 multiply-accumulate unit. A filter word is taken when the core is
// idle and then runs each active section in turn (five coefficient reads and
// products into a 35-bit accumulator, then shift, saturate and history update);
// the input stalls until the last section is done, which waits while the output
// register still holds a word not yet taken. Coefficient writes and history clears
// are taken when idle and give no output word. The coefficient memory reads as zero
// until an entry is written; a clear command zeroes all section history at once and
// keeps the coefficients. num_stages of 0 acts as 1, values above eight act as eight.
// A finished word waits in the output register while the next word is taken.
module biquad_cascade_df1_q15_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic [2:0]          stage_sel,
  input  logic [2:0]          coef_slot,
  input  logic signed [15:0]  coef_value,
  input  logic signed [15:0]  sample_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  sample_out,
  input  logic                cfg_wen,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_data
);

  biq_pkg::state_t state, state_next;

  logic [3:0] num_stages;
  logic [3:0] post_shift;

  logic signed [15:0] coef_mem [biq_pkg::COEF_DEPTH];
  logic [biq_pkg::COEF_DEPTH-1:0] coef_vld;
  logic signed [15:0] hist [biq_pkg::HIST_DEPTH];

  logic [biq_pkg::STEP_W-1:0]  cnt;
  logic [biq_pkg::STAGE_W-1:0] stage;

  logic signed [15:0] x;
  logic signed [15:0] x1s;
  logic signed [15:0] y1s;
  logic signed [15:0] coef_q;
  logic signed [15:0] hist_q;
  logic signed [31:0] prod;
  logic signed [biq_pkg::ACC_W-1:0] acc;

  logic in_accept;
  logic start;
  logic advance;
  logic finish;
  logic last_stage;
  logic [3:0] last_idx;
  logic [3:0] shamt;
  logic signed [15:0] operand;
  logic signed [15:0] y_val;
  logic [biq_pkg::COEF_AW-1:0] coef_wr_addr;
  logic [biq_pkg::COEF_AW-1:0] coef_rd_addr;
  logic [biq_pkg::HIST_AW-1:0] hist_rd_addr;
  logic [biq_pkg::HIST_AW-1:0] hist_base;
  logic coef_wr_ok;

  assign in_stall  = (state != biq_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign start     = in_accept && (cmd == biq_pkg::CMD_FILTER);

  always_comb begin
    if (num_stages == 4'd0) begin
      last_idx = 4'd0;
    end else if (int'(num_stages) > biq_pkg::MAX_STAGES) begin
      last_idx = 4'(biq_pkg::MAX_STAGES - 1);
    end else begin
      last_idx = num_stages - 4'd1;
    end
  end

  assign last_stage = (int'(stage) == int'(last_idx));
  assign shamt      = 4'(biq_pkg::FRAC_BITS) - post_shift;
  assign y_val      = biq_pkg::sat16(acc >>> shamt);
  assign operand    = (cnt == 3'd1) ? x : hist_q;

  assign coef_wr_ok   = (coef_slot <= biq_pkg::SLOT_LAST) &&
                        (int'(stage_sel) < biq_pkg::MAX_STAGES);
  assign coef_wr_addr = biq_pkg::COEF_AW'(int'(stage_sel) * biq_pkg::NUM_COEF +
                                          int'(coef_slot));
  assign coef_rd_addr = biq_pkg::COEF_AW'(int'(stage) * biq_pkg::NUM_COEF + int'(cnt));
  assign hist_base    = biq_pkg::HIST_AW'(int'(stage) * biq_pkg::NUM_HIST);
  assign hist_rd_addr = biq_pkg::HIST_AW'(int'(stage) * biq_pkg::NUM_HIST +
                                          int'(cnt - 3'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= biq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    advance    = 1'b0;
    finish     = 1'b0;
    case (state)
      biq_pkg::ST_IDLE: begin
        if (start) begin
          state_next = biq_pkg::ST_RUN;
        end
      end
      biq_pkg::ST_RUN: begin
        if (cnt == biq_pkg::STEP_OUT) begin
          if (!last_stage) begin
            advance = 1'b1;
          end else if (!out_valid || !out_stall) begin
            advance    = 1'b1;
            finish     = 1'b1;
            state_next = biq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = biq_pkg::ST_IDLE;
      end
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_stages <= 4'd1;
      post_shift <= 4'd0;
    end else if (cfg_wen) begin
      case (cfg_index)
        biq_pkg::CFG_NUM_STAGES: num_stages <= cfg_data;
        biq_pkg::CFG_POST_SHIFT: post_shift <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      stage <= '0;
    end else if (start) begin
      cnt   <= '0;
      stage <= '0;
    end else if (state == biq_pkg::ST_RUN) begin
      if (cnt == biq_pkg::STEP_OUT) begin
        if (advance) begin
          cnt <= '0;
          if (finish) begin
            stage <= '0;
          end else begin
            stage <= stage + biq_pkg::STAGE_W'(1);
          end
        end
      end else begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (in_accept && (cmd == biq_pkg::CMD_COEF) && coef_wr_ok) begin
      coef_mem[coef_wr_addr] <= coef_value;
    end
    if (cnt <= biq_pkg::STEP_ISSUE_END) begin
      coef_q <= coef_vld[coef_rd_addr] ? coef_mem[coef_rd_addr] : 16'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
    end else if (in_accept && (cmd == biq_pkg::CMD_COEF) && coef_wr_ok) begin
      coef_vld[coef_wr_addr] <= 1'b1;
    end
  end

  // section history
  always_ff @(posedge clk) begin
    if (rst || (in_accept && (cmd == biq_pkg::CMD_CLEAR))) begin
      for (int i = 0; i < biq_pkg::HIST_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else if (advance) begin
      hist[hist_base]                        <= x;
      hist[hist_base + biq_pkg::HIST_AW'(1)] <= x1s;
      hist[hist_base + biq_pkg::HIST_AW'(2)] <= y_val;
      hist[hist_base + biq_pkg::HIST_AW'(3)] <= y1s;
    end
  end

  always_ff @(posedge clk) begin
    if ((cnt >= 3'd1) && (cnt <= biq_pkg::STEP_ISSUE_END)) begin
      hist_q <= hist[hist_rd_addr];
    end
  end

  // shared multiply-accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      x <= sample_in;
    end else if (advance) begin
      x <= y_val;
    end
    if (cnt == biq_pkg::STEP_X1) begin
      x1s <= hist_q;
    end
    if (cnt == biq_pkg::STEP_Y1) begin
      y1s <= hist_q;
    end
    prod <= coef_q * operand;
    if (cnt == biq_pkg::STEP_ACC_FIRST) begin
      acc <= biq_pkg::ACC_W'(prod);
    end else if ((cnt > biq_pkg::STEP_ACC_FIRST) && (cnt <= biq_pkg::STEP_ACC_LAST)) begin
      acc <= acc + biq_pkg::ACC_W'(prod);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      sample_out <= y_val;
    end
  end

  a_finish_shows_word: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid && (sample_out == $past(y_val)))
    else $error("finished word not presented");

  a_filter_holds_input: assert property (@(posedge clk) disable iff (rst)
    start |=> in_stall)
    else $error("input not stalled after filter word");

  a_counter_only_in_run: assert property (@(posedge clk) disable iff (rst)
    (cnt != 3'd0) |-> (state == biq_pkg::ST_RUN))
    else $error("step counter moving while idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !finish)
    else $error("pending output word overwritten");

endmodule
